// ----- design/barycentric_coordinates_3d_core_defines.svh -----
// assertion macros shared by the barycentric core checker
// depends on: nothing; the including scope provides clk and rst_n
`ifndef BARYCENTRIC_COORDINATES_3D_CORE_DEFINES_SVH
`define BARYCENTRIC_COORDINATES_3D_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BCC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bcc_pkg.sv -----
// shared widths, beat types and arithmetic helpers of the barycentric core
// depends on: nothing
package bcc_pkg;

  localparam int COORD_WIDTH = 12;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_WIDTH   = 20;

  // derived widths
  localparam int DW         = COORD_WIDTH + 1;   // edge vector component
  localparam int DOTW       = 2 * DW + 2;        // dot product
  localparam int PW         = 2 * DOTW;          // gram product
  localparam int NW         = PW + 3;            // determinant and numerators
  localparam int MW         = NW;                // magnitudes
  localparam int QW         = OUT_WIDTH + 1;     // quotient bits below overflow
  localparam int RW         = MW + ((FRAC_BITS > QW) ? FRAC_BITS : QW) + 1;
  localparam int DIV_STAGES = QW + 1;

  localparam logic [QW:0] SAT_POS_MAG = ((QW+1)'(1) << (OUT_WIDTH - 1)) - (QW+1)'(1);
  localparam logic [QW:0] SAT_NEG_MAG = (QW+1)'(1) << (OUT_WIDTH - 1);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [COORD_WIDTH-1:0] va_x;
    logic signed [COORD_WIDTH-1:0] va_y;
    logic signed [COORD_WIDTH-1:0] va_z;
    logic signed [COORD_WIDTH-1:0] vb_x;
    logic signed [COORD_WIDTH-1:0] vb_y;
    logic signed [COORD_WIDTH-1:0] vb_z;
    logic signed [COORD_WIDTH-1:0] vc_x;
    logic signed [COORD_WIDTH-1:0] vc_y;
    logic signed [COORD_WIDTH-1:0] vc_z;
  } in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] weight_u;
    logic signed [OUT_WIDTH-1:0] weight_v;
    logic signed [OUT_WIDTH-1:0] weight_w;
    logic                        degenerate;
  } out_t;

  typedef struct packed {
    logic signed [DOTW-1:0] d00;
    logic signed [DOTW-1:0] d01;
    logic signed [DOTW-1:0] d11;
    logic signed [DOTW-1:0] d20;
    logic signed [DOTW-1:0] d21;
  } dots_t;

  // divisor magnitude, three numerator magnitudes and their result signs
  typedef struct packed {
    logic                   deg;
    logic [MW-1:0]          md;
    logic [2:0][MW-1:0]     mn;
    logic [2:0]             neg;
  } ratio_t;

  typedef struct packed {
    logic                   deg;
    logic [2:0][QW:0]       q;
    logic [2:0]             neg;
  } quo_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic          qbit;
  } step_t;

  // one restoring division step against the divisor shifted by k
  function automatic step_t div_step(input logic [RW-1:0] rem, input logic [MW-1:0] md,
                                     input int k);
    logic [RW-1:0] sh;
    step_t         r;
    sh = RW'(md) << k;
    if (rem >= sh) begin
      r.rem  = rem - sh;
      r.qbit = 1'b1;
    end else begin
      r.rem  = rem;
      r.qbit = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [NW-1:0] a);
    logic signed [NW-1:0] na;
    na = -a;
    return a[NW-1] ? MW'(na) : MW'(a);
  endfunction

endpackage

// ----- design/bcc_dot.sv -----
// edge vectors and the five dot products, two register stages
// depends on: bcc_pkg
module bcc_dot (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bcc_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bcc_pkg::dots_t  out_data
);
  import bcc_pkg::*;

  logic signed [DW-1:0] e1_r [3];
  logic signed [DW-1:0] e2_r [3];
  logic signed [DW-1:0] t_r  [3];
  logic signed [DW-1:0] e1_nxt [3];
  logic signed [DW-1:0] e2_nxt [3];
  logic signed [DW-1:0] t_nxt  [3];
  logic signed [COORD_WIDTH-1:0] p [3];
  logic signed [COORD_WIDTH-1:0] a [3];
  logic signed [COORD_WIDTH-1:0] b [3];
  logic signed [COORD_WIDTH-1:0] c [3];
  logic  v1_r, v2_r, en1, en2;
  dots_t dots_r, dots_nxt;

  // stage enables collapse bubbles
  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // edge and point vectors relative to vertex a
  always_comb begin
    p = '{in_data.point_x, in_data.point_y, in_data.point_z};
    a = '{in_data.va_x, in_data.va_y, in_data.va_z};
    b = '{in_data.vb_x, in_data.vb_y, in_data.vb_z};
    c = '{in_data.vc_x, in_data.vc_y, in_data.vc_z};
    for (int i = 0; i < 3; i++) begin
      e1_nxt[i] = DW'(b[i]) - DW'(a[i]);
      e2_nxt[i] = DW'(c[i]) - DW'(a[i]);
      t_nxt[i]  = DW'(p[i]) - DW'(a[i]);
    end
  end

  // dot products of the registered vectors
  function automatic logic signed [DOTW-1:0] dot3(input logic signed [DW-1:0] x0,
      input logic signed [DW-1:0] x1, input logic signed [DW-1:0] x2,
      input logic signed [DW-1:0] y0, input logic signed [DW-1:0] y1,
      input logic signed [DW-1:0] y2);
    logic signed [2*DW-1:0] m0, m1, m2;
    m0 = x0 * y0;
    m1 = x1 * y1;
    m2 = x2 * y2;
    return DOTW'(m0) + DOTW'(m1) + DOTW'(m2);
  endfunction

  always_comb begin
    dots_nxt.d00 = dot3(e1_r[0], e1_r[1], e1_r[2], e1_r[0], e1_r[1], e1_r[2]);
    dots_nxt.d01 = dot3(e1_r[0], e1_r[1], e1_r[2], e2_r[0], e2_r[1], e2_r[2]);
    dots_nxt.d11 = dot3(e2_r[0], e2_r[1], e2_r[2], e2_r[0], e2_r[1], e2_r[2]);
    dots_nxt.d20 = dot3(t_r[0], t_r[1], t_r[2], e1_r[0], e1_r[1], e1_r[2]);
    dots_nxt.d21 = dot3(t_r[0], t_r[1], t_r[2], e2_r[0], e2_r[1], e2_r[2]);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      e1_r <= e1_nxt;
      e2_r <= e2_nxt;
      t_r  <= t_nxt;
    end
    if (en2 && v1_r) dots_r <= dots_nxt;
  end

  assign out_valid = v2_r;
  assign out_data  = dots_r;

endmodule

// ----- design/bcc_gram.sv -----
// gram determinant, weight numerators and their magnitudes, four stages
// depends on: bcc_pkg
module bcc_gram (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bcc_pkg::dots_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bcc_pkg::ratio_t  out_data
);
  import bcc_pkg::*;

  logic signed [PW-1:0] pr_r [6];
  logic signed [PW-1:0] pr_nxt [6];
  logic signed [NW-1:0] det_r, nu_r, nv_r;
  logic signed [NW-1:0] det2_r, nu2_r, nv2_r, nw2_r;
  logic [3:0] v_r, en;
  ratio_t rat_r, rat_nxt;

  assign en[3]    = !v_r[3] || out_ready;
  assign en[2]    = !v_r[2] || en[3];
  assign en[1]    = !v_r[1] || en[2];
  assign en[0]    = !v_r[0] || en[1];
  assign in_ready = en[0];

  // six gram products
  always_comb begin
    pr_nxt[0] = in_data.d00 * in_data.d11;
    pr_nxt[1] = in_data.d01 * in_data.d01;
    pr_nxt[2] = in_data.d11 * in_data.d20;
    pr_nxt[3] = in_data.d01 * in_data.d21;
    pr_nxt[4] = in_data.d00 * in_data.d21;
    pr_nxt[5] = in_data.d01 * in_data.d20;
  end

  // magnitudes, result signs and zero determinant
  always_comb begin
    rat_nxt.deg    = (det2_r == '0);
    rat_nxt.md     = mag(det2_r);
    rat_nxt.mn[0]  = mag(nu2_r);
    rat_nxt.mn[1]  = mag(nv2_r);
    rat_nxt.mn[2]  = mag(nw2_r);
    rat_nxt.neg[0] = nu2_r[NW-1] ^ det2_r[NW-1];
    rat_nxt.neg[1] = nv2_r[NW-1] ^ det2_r[NW-1];
    rat_nxt.neg[2] = nw2_r[NW-1] ^ det2_r[NW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) pr_r <= pr_nxt;
    // determinant and u, v numerators
    if (en[1] && v_r[0]) begin
      det_r <= NW'(pr_r[0]) - NW'(pr_r[1]);
      nu_r  <= NW'(pr_r[2]) - NW'(pr_r[3]);
      nv_r  <= NW'(pr_r[4]) - NW'(pr_r[5]);
    end
    // w numerator is det - nu - nv
    if (en[2] && v_r[1]) begin
      det2_r <= det_r;
      nu2_r  <= nu_r;
      nv2_r  <= nv_r;
      nw2_r  <= det_r - nu_r - nv_r;
    end
    if (en[3] && v_r[2]) rat_r <= rat_nxt;
  end

  assign out_valid = v_r[3];
  assign out_data  = rat_r;

endmodule

// ----- design/bcc_div.sv -----
// pipelined restoring divider, one quotient bit per stage for three lanes
// that share one divisor; the first stage only detects overflow
// depends on: bcc_pkg
module bcc_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bcc_pkg::ratio_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bcc_pkg::quo_t    out_data
);
  import bcc_pkg::*;

  typedef struct packed {
    logic                   deg;
    logic [MW-1:0]          md;
    logic [2:0][RW-1:0]     rem;
    logic [2:0][QW:0]       q;
    logic [2:0]             neg;
  } dstage_t;

  dstage_t stg_r   [DIV_STAGES];
  dstage_t stg_nxt [DIV_STAGES];
  dstage_t src     [DIV_STAGES];
  logic [DIV_STAGES-1:0] v_r, en, src_v;

  // entry: numerator magnitudes scaled by the fraction bits
  always_comb begin
    src[0].deg = in_data.deg;
    src[0].md  = in_data.md;
    src[0].neg = in_data.neg;
    for (int j = 0; j < 3; j++) begin
      src[0].rem[j] = RW'(in_data.mn[j]) << FRAC_BITS;
      src[0].q[j]   = '0;
    end
  end
  assign src_v[0] = in_valid;

  assign en[DIV_STAGES-1] = !v_r[DIV_STAGES-1] || out_ready;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    if (s > 0) begin : g_link
      assign src[s]   = stg_r[s-1];
      assign src_v[s] = v_r[s-1];
    end
    if (s < DIV_STAGES - 1) begin : g_en
      assign en[s] = !v_r[s] || en[s+1];
    end

    // compare and subtract against divisor shifted to this bit
    always_comb begin
      step_t st;
      stg_nxt[s] = src[s];
      for (int j = 0; j < 3; j++) begin
        st = div_step(src[s].rem[j], src[s].md, QW - s);
        stg_nxt[s].rem[j] = st.rem;
        stg_nxt[s].q[j]   = {src[s].q[j][QW-1:0], st.qbit};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s] <= src_v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s] && src_v[s]) stg_r[s] <= stg_nxt[s];
    end
  end

  assign in_ready      = en[0];
  assign out_valid     = v_r[DIV_STAGES-1];
  assign out_data.deg  = stg_r[DIV_STAGES-1].deg;
  assign out_data.q    = stg_r[DIV_STAGES-1].q;
  assign out_data.neg  = stg_r[DIV_STAGES-1].neg;

endmodule

// ----- design/barycentric_coordinates_3d_core.sv -----
// Barycentric weights of a 3D point against a triangle by the dot-product
// method. One beat in per clock unless the output stalls, one result beat
// out per input beat, in order. The path is registered in edge vectors and
// dot products, then gram determinant, numerators and magnitudes, then the
// divider (one quotient bit per stage, OUT_WIDTH + 2 stages) and last the
// saturating output register. Throughput is one item per cycle while the
// output does not stall; empty stages fill while the output waits. Weights
// are Q4.16 truncated toward zero and saturated; a zero determinant gives
// degenerate with zero weights.
// depends on: bcc_pkg, bcc_dot, bcc_gram, bcc_div
module barycentric_coordinates_3d_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bcc_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output bcc_pkg::out_t  out_data
);
  import bcc_pkg::*;

  logic   dot_valid, dot_ready, gram_valid, gram_ready, div_valid, div_ready;
  dots_t  dot_data;
  ratio_t gram_data;
  quo_t   div_data;
  logic   out_valid_r;
  out_t   out_r, out_nxt;
  logic signed [OUT_WIDTH-1:0] wt [3];

  bcc_dot u_dot (
    .clk, .rst_n,
    .in_valid (in_valid),  .in_ready (in_ready),  .in_data (in_data),
    .out_valid(dot_valid), .out_ready(dot_ready), .out_data(dot_data)
  );

  bcc_gram u_gram (
    .clk, .rst_n,
    .in_valid (dot_valid),  .in_ready (dot_ready),  .in_data (dot_data),
    .out_valid(gram_valid), .out_ready(gram_ready), .out_data(gram_data)
  );

  bcc_div u_div (
    .clk, .rst_n,
    .in_valid (gram_valid), .in_ready (gram_ready), .in_data (gram_data),
    .out_valid(div_valid),  .out_ready(div_ready),  .out_data(div_data)
  );

  assign div_ready = !out_valid_r || out_ready;

  // sign and saturate each quotient
  always_comb begin
    logic [QW:0] nq;
    for (int j = 0; j < 3; j++) begin
      nq = -div_data.q[j];
      if (div_data.deg) begin
        wt[j] = '0;
      end else if (div_data.neg[j]) begin
        wt[j] = (div_data.q[j] > SAT_NEG_MAG) ? OUT_WIDTH'(-SAT_NEG_MAG) : OUT_WIDTH'(nq);
      end else begin
        wt[j] = (div_data.q[j] > SAT_POS_MAG) ? OUT_WIDTH'(SAT_POS_MAG)
                                              : OUT_WIDTH'(div_data.q[j]);
      end
    end
    out_nxt.weight_u   = wt[0];
    out_nxt.weight_v   = wt[1];
    out_nxt.weight_w   = wt[2];
    out_nxt.degenerate = div_data.deg;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_ready) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready && div_valid) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- design/bcc_checker.sv -----
// port-level checks of the barycentric core, attached by bind
// depends on: bcc_pkg, barycentric_coordinates_3d_core_defines.svh
`include "barycentric_coordinates_3d_core_defines.svh"

module bcc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input bcc_pkg::out_t out_data,
  input logic          out_valid,
  input logic          out_ready
);

  // a stalled result beat stays up and unchanged
  `BCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
  `BCC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "payload changed")

  // degenerate triangles report zero weights
  `BCC_ASSERT_IMPL(a_deg_zero, out_valid && out_data.degenerate,
                   out_data.weight_u == '0 && out_data.weight_v == '0 &&
                   out_data.weight_w == '0, "degenerate beat with nonzero weight")

  // an empty or draining output stage lets every stage move, so input is taken
  `BCC_ASSERT_IMPL(a_ready_flow, !out_valid || out_ready, in_ready,
                   "input stalled while output side free")

endmodule

bind barycentric_coordinates_3d_core bcc_checker u_bcc_checker (.*);

// ----- sim/bcc_weight_checker.sv -----
// checker for the barycentric core: watches both channels, predicts weights
// depends on: bcc_pkg
`timescale 1ns / 100ps

module bcc_weight_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  bcc_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  bcc_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);
  import bcc_pkg::*;

  out_t weights_due[$];

  // quotient num * 2^FRAC_BITS / det, truncated toward zero, then clamped
  function automatic logic signed [OUT_WIDTH-1:0] sat_ratio(
      input logic signed [127:0] num, input logic signed [127:0] det);
    logic signed [191:0] q;
    logic signed [191:0] sn;
    logic signed [191:0] sd;
    sn = num;
    sd = det;
    q = (sn <<< FRAC_BITS) / sd;
    if (q > 192'sd524287) return 20'sd524287;
    if (q < -192'sd524288) return -20'sd524288;
    return q[OUT_WIDTH-1:0];
  endfunction

  function automatic out_t weights_of(input in_t s);
    logic signed [127:0] p[3], a[3], b[3], c[3], e1[3], e2[3], t[3];
    logic signed [127:0] d00, d01, d11, d20, d21, det, nu, nv;
    out_t r;
    p = '{s.point_x, s.point_y, s.point_z};
    a = '{s.va_x, s.va_y, s.va_z};
    b = '{s.vb_x, s.vb_y, s.vb_z};
    c = '{s.vc_x, s.vc_y, s.vc_z};
    d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
      t[i]  = p[i] - a[i];
      d00 += e1[i] * e1[i];
      d01 += e1[i] * e2[i];
      d11 += e2[i] * e2[i];
      d20 += t[i] * e1[i];
      d21 += t[i] * e2[i];
    end
    det = d00 * d11 - d01 * d01;
    nu  = d11 * d20 - d01 * d21;
    nv  = d00 * d21 - d01 * d20;
    r = '0;
    if (det == 0) begin
      r.degenerate = 1'b1;
    end else begin
      r.weight_u = sat_ratio(nu, det);
      r.weight_v = sat_ratio(nv, det);
      r.weight_w = sat_ratio(det - nu - nv, det);
    end
    return r;
  endfunction

  assign pending = weights_due.size();

  // predict on each input beat, compare on each result beat
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) weights_due.push_back(weights_of(in_data));
      if (out_valid && out_ready) begin
        if (weights_due.size() == 0) begin
          $error("result beat with no expectation");
          fail_count <= fail_count + 1;
        end else begin
          want = weights_due.pop_front();
          if (out_data !== want) begin
            if (out_data.weight_u !== want.weight_u)
              $error("weight_u exp %0d got %0d", want.weight_u, out_data.weight_u);
            if (out_data.weight_v !== want.weight_v)
              $error("weight_v exp %0d got %0d", want.weight_v, out_data.weight_v);
            if (out_data.weight_w !== want.weight_w)
              $error("weight_w exp %0d got %0d", want.weight_w, out_data.weight_w);
            if (out_data.degenerate !== want.degenerate)
              $error("degenerate exp %0b got %0b", want.degenerate, out_data.degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- sim/tb_barycentric_coordinates_3d_core.sv -----
// stimulus and verdict for the barycentric core
// depends on: bcc_pkg, barycentric_coordinates_3d_core, bcc_weight_checker
`timescale 1ns / 100ps

module tb_barycentric_coordinates_3d_core;
  import bcc_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;
  bit   calm = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  barycentric_coordinates_3d_core uut (.*);

  bcc_weight_checker chk (.*);

  // receiver stalls, none during the calm stretch
  always @(posedge clk)
    out_ready <= rst_n && (calm || $urandom_range(99) >= 19);

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_barycentric_coordinates_3d_core failed");
      $finish;
    end
  end

  function automatic logic [11:0] corner(input int sel);
    case (sel)
      0: return 12'h800;
      1: return 12'h7ff;
      2: return 12'h000;
      3: return 12'hfff;
      default: return 12'($urandom);
    endcase
  endfunction

  // one beat; idle gaps only before raising valid, valid stays up between beats
  task automatic send_beat(input in_t s);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid and wait until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic in_t small_triangle();
    in_t s;
    int  spread;
    spread = $urandom_range(3) == 0 ? 2047 : $urandom_range(1, 64);
    s = in_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    s.va_x = 12'($urandom_range(4095));
    s.vb_x = s.va_x + 12'($urandom_range(2 * spread) - spread);
    s.vb_y = s.va_y + 12'($urandom_range(2 * spread) - spread);
    s.vb_z = s.va_z + 12'($urandom_range(2 * spread) - spread);
    s.vc_x = s.va_x + 12'($urandom_range(2 * spread) - spread);
    s.vc_y = s.va_y + 12'($urandom_range(2 * spread) - spread);
    s.vc_z = s.va_z + 12'($urandom_range(2 * spread) - spread);
    s.point_x = s.va_x + 12'($urandom_range(4 * spread) - 2 * spread);
    s.point_y = s.va_y + 12'($urandom_range(4 * spread) - 2 * spread);
    s.point_z = s.va_z + 12'($urandom_range(4 * spread) - 2 * spread);
    return s;
  endfunction

  initial begin
    in_t s;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corner values in every field, degenerate and collinear cases
    for (int k = 0; k < 6; k++) begin
      for (int f = 0; f < 12; f++) s[f*12 +: 12] = corner(k < 4 ? k : 4);
      send_beat(s);
    end
    s = '0;
    send_beat(s);                      // all vertices equal
    s.vb_x = 12'd5; s.vc_x = 12'd9;    // collinear
    send_beat(s);
    s = '0; s.vb_x = 12'd1; s.vc_y = 12'd1; s.point_x = 12'h7ff;  // saturates
    send_beat(s);
    s.point_x = 12'h800; send_beat(s);
    s.point_x = 12'd0; s.point_y = 12'd0; send_beat(s);  // point on vertex
    s = '0; s.va_x = 12'h800; s.vb_x = 12'h7ff; s.vc_y = 12'h7ff; s.vc_z = 12'h800;
    s.point_z = 12'h7ff;
    send_beat(s);

    // sender holds off until everything drains
    drain();

    for (int n = 0; n < 500; n++) begin
      calm = (n >= 200 && n < 280);
      if ($urandom_range(9) == 0)
        s = in_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      else s = small_triangle();
      if ($urandom_range(19) == 0) s.vc_x = s.vb_x;
      if ($urandom_range(19) == 0) begin
        s.vc_y = s.vb_y; s.vc_z = s.vb_z; s.vc_x = s.vb_x;
      end
      send_beat(s);
    end
    calm = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("tb_barycentric_coordinates_3d_core passed");
    else
      $display("tb_barycentric_coordinates_3d_core failed");
    $finish;
  end
endmodule
